// ----- hdl/ipds_pkg.sv -----
// shared constants, types and helpers of the image pair difference statistics block
// no dependencies
package ipds_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int GEOM_W   = 11;
	localparam int COORD_W  = 32;
	localparam int BITSEL_W = 5;
	localparam int MASK_W   = 32;
	localparam int COUNT_W  = 21;
	localparam int SUM_W    = 37;

	localparam int IN_DATA_W    = 6 * SAMPLE_BITS;
	localparam int OUT_FIELDS_W = 3 * SAMPLE_BITS + 3 * COUNT_W + 2 * COORD_W + 3 * SUM_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_STRUCT_BIT   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CENSOR_BIT   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_BOUND_BIT    = 3'd6;

	// luma weights, Q0.16
	localparam int WEIGHT_FRAC = 16;
	localparam logic [WEIGHT_FRAC-1:0] W_RED   = 16'd13933;
	localparam logic [WEIGHT_FRAC-1:0] W_GREEN = 16'd46871;
	localparam logic [WEIGHT_FRAC-1:0] W_BLUE  = 16'd4732;

	localparam int MAC_W  = SAMPLE_BITS + 3;
	localparam int ACC_W  = 2 * MAC_W + 2;
	localparam int RAD_W  = 2 * SAMPLE_BITS + 4;
	localparam int ROOT_W = RAD_W / 2;
	localparam int DIV_DIGIT  = 4;
	localparam int DIV_STEPS  = RAD_W / DIV_DIGIT;
	localparam logic [ACC_W-1:0] LUMA_ROUND = ACC_W'(1) << (WEIGHT_FRAC - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LUMA_A,
		ST_LUMA_B,
		ST_SUM_D,
		ST_CHROMA,
		ST_DIV,
		ST_ROOT_CH,
		ST_GRAD_R,
		ST_ROOT_GR,
		ST_GRAD_C,
		ST_ROOT_GC,
		ST_FIN
	} ipds_state_t;

	function automatic logic [WEIGHT_FRAC-1:0] luma_weight(input logic [1:0] k);
		logic [WEIGHT_FRAC-1:0] w;
		case (k)
			2'd0: w = W_RED;
			2'd1: w = W_GREEN;
			2'd2: w = W_BLUE;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// ----- hdl/ipds_root.sv -----
// iterative integer square root, one result bit per cycle
// uses nothing outside this file
module ipds_root #(
	parameter int RAD_BITS = 36
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [RAD_BITS-1:0]   radicand,
	output logic                  busy,
	output logic [RAD_BITS/2-1:0] root
);

	localparam int RW = RAD_BITS / 2;
	localparam int CNT_W = $clog2(RW + 1);

	logic [CNT_W-1:0]    cnt_q;
	logic [RAD_BITS-1:0] rad_q;
	logic [RW+1:0]       rem_q;
	logic [RW-1:0]       root_q;
	logic [RW+3:0]       rem_t;
	logic [RW+3:0]       trial;
	logic                fits;

	assign busy  = cnt_q != '0;
	assign root  = root_q;
	assign rem_t = {rem_q, rad_q[RAD_BITS-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = rem_t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(RW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy) begin
			rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
			rem_q  <= fits ? (RW+2)'(rem_t - trial) : (RW+2)'(rem_t);
			root_q <= {root_q[RW-2:0], fits};
		end
	end

endmodule

// ----- hdl/image_pair_difference_stats.sv -----
// top level of the image pair difference statistics block
// depends on ipds_pkg and ipds_root
//
// Takes one pixel pair per transaction in raster order and returns one result per pixel.
// Pixels on the first row and first column skip the gradient steps. One shared multiply-
// accumulate unit forms both lumas, the signed delta luma, the chroma sum of squares and the
// gradient sums of squares one term at a time, a divide by three runs four bits a cycle,
// and one square root unit producing one bit a cycle is shared by the chroma delta and both
// gradient magnitudes. The next pixel is taken once the result has moved into the output
// register. Frame totals appear on the transaction with tlast set and are zero on others;
// all frame accumulators then clear. The previous-row luma store is not cleared at reset.
module image_pair_difference_stats
	import ipds_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// ref_red, ref_green, ref_blue, cand_red, cand_green, cand_blue
	input  logic [IN_DATA_W-1:0]   s_tdata,
	// reason_mask
	input  logic [MASK_W-1:0]      s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// peak_channel_delta, luma_delta, chroma_delta, changed_total, structure_total,
	// censor_total, worst_x, worst_y, edge_sum_ref, edge_sum_cand, edge_gap_sum, zero fill
	output logic [OUT_DATA_W-1:0]  m_tdata,
	// frame_last
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int SB  = SAMPLE_BITS;
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RWD = $clog2(MAX_HEIGHT);

	ipds_state_t state_q, state_d;
	logic [3:0]  step_q;
	logic        root_start;
	logic        root_busy;
	logic [ROOT_W-1:0] root_val;
	logic [RAD_W-1:0]  root_rad;

	// configuration
	logic [GEOM_W-1:0]   frame_width_q, frame_height_q;
	logic [COORD_W-1:0]  origin_x_q, origin_y_q;
	logic [BITSEL_W-1:0] struct_bit_q, censor_bit_q, bound_bit_q;

	// item registers
	logic [SB-1:0]     a_q [3];
	logic [SB-1:0]     b_q [3];
	logic [MASK_W-1:0] mask_q;
	logic [SB-1:0]     peak_q;
	logic [SB-1:0]     in_peak;
	logic [SB-1:0]     in_abs [3];

	// arithmetic
	logic signed [SB:0]        d [3];
	logic signed [MAC_W-1:0]   c [3];
	logic signed [MAC_W-1:0]   mac_x, mac_y;
	logic signed [2*MAC_W-1:0] prod;
	logic signed [ACC_W-1:0]   acc_q, acc_nxt;
	logic [SB-1:0]             la_q, lb_q;
	logic signed [SB+1:0]      sl_q;
	logic [RAD_W-1:0]          rad_q;
	logic [1:0]                rem3_q, div_rem;
	logic [DIV_DIGIT-1:0]      div_q;
	logic [SB-1:0]             chroma_q;
	logic [ROOT_W-1:0]         ga_q;
	logic signed [SB:0]        gx_ref, gy_ref, gx_cand, gy_cand;
	logic [1:0]                k;
	logic                      last3;

	// frame state
	logic [CW-1:0]      col_q, best_col_q, bcol_n;
	logic [RWD-1:0]     row_q, best_row_q, brow_n;
	logic [SB-1:0]      best_delta_q;
	logic               best_seen_q, take_best;
	logic [COUNT_W-1:0] changed_q, struct_q, censor_q, changed_n, struct_n, censor_n;
	logic [SUM_W-1:0]   sum_ref_q, sum_cand_q, gap_q, sum_ref_n, sum_cand_n, gap_n;
	logic [SB-1:0]      left_ref_q, left_cand_q, diag_ref_q, diag_cand_q;
	logic [2*SB-1:0]    up_q;
	logic [2*SB-1:0]    line_mem [MAX_WIDTH];
	logic               grad_en, out_free, fin_go, row_end, frame_end;
	logic [31:0]        w_lim, h_lim;
	logic [ROOT_W-1:0]  gb, g_gap;
	logic [SB-1:0]      luma_abs, chroma_sat;
	logic [COORD_W-1:0] worst_x, worst_y;

	logic              m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic              m_tlast_q;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tlast   = m_tlast_q;
	assign s_tready  = state_q == ST_IDLE;

	assign k     = step_q[1:0];
	assign last3 = k == 2'd2;

	// input peak delta
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [SB-1:0] ra, rb;
			ra = s_tdata[i*SB +: SB];
			rb = s_tdata[(i+3)*SB +: SB];
			in_abs[i] = (rb > ra) ? SB'(rb - ra) : SB'(ra - rb);
		end
		in_peak = in_abs[0];
		if (in_abs[1] > in_peak) in_peak = in_abs[1];
		if (in_abs[2] > in_peak) in_peak = in_abs[2];
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i] = $signed({1'b0, b_q[i]}) - $signed({1'b0, a_q[i]});
			c[i] = MAC_W'(d[i]) - MAC_W'(sl_q);
		end
	end

	assign gx_ref  = $signed({1'b0, up_q[SB-1:0]}) - $signed({1'b0, diag_ref_q});
	assign gy_ref  = $signed({1'b0, left_ref_q}) - $signed({1'b0, diag_ref_q});
	assign gx_cand = $signed({1'b0, up_q[2*SB-1:SB]}) - $signed({1'b0, diag_cand_q});
	assign gy_cand = $signed({1'b0, left_cand_q}) - $signed({1'b0, diag_cand_q});

	// shared multiply-accumulate operands
	always_comb begin
		mac_x = '0;
		mac_y = '0;
		case (state_q)
			ST_LUMA_A: begin
				mac_x = MAC_W'($signed({1'b0, luma_weight(k)}));
				mac_y = MAC_W'($signed({1'b0, a_q[k]}));
			end
			ST_LUMA_B: begin
				mac_x = MAC_W'($signed({1'b0, luma_weight(k)}));
				mac_y = MAC_W'($signed({1'b0, b_q[k]}));
			end
			ST_SUM_D: begin
				mac_x = MAC_W'($signed({1'b0, luma_weight(k)}));
				mac_y = MAC_W'(d[k]);
			end
			ST_CHROMA: begin
				mac_x = c[k];
				mac_y = c[k];
			end
			ST_GRAD_R: begin
				mac_x = step_q[0] ? MAC_W'(gy_ref) : MAC_W'(gx_ref);
				mac_y = mac_x;
			end
			ST_GRAD_C: begin
				mac_x = step_q[0] ? MAC_W'(gy_cand) : MAC_W'(gx_cand);
				mac_y = mac_x;
			end
			default: begin
				mac_x = '0;
				mac_y = '0;
			end
		endcase
	end

	assign prod    = mac_x * mac_y;
	assign acc_nxt = acc_q + ACC_W'(prod);

	// divide by three, four quotient bits a cycle
	always_comb begin
		logic [2:0] t;
		logic [1:0] r;
		r = rem3_q;
		div_q = '0;
		for (int i = 0; i < DIV_DIGIT; i++) begin
			t = {r, rad_q[RAD_W-1-i]};
			div_q[DIV_DIGIT-1-i] = t >= 3'd3;
			r = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
		end
		div_rem = r;
	end

	assign root_rad = (state_q == ST_DIV) ? {rad_q[RAD_W-DIV_DIGIT-1:0], div_q}
	                                      : acc_nxt[RAD_W-1:0];

	ipds_root #(
		.RAD_BITS(RAD_W)
	) u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (root_rad),
		.busy     (root_busy),
		.root     (root_val)
	);

	// frame bookkeeping
	always_comb begin
		w_lim = (frame_width_q < GEOM_W'(2)) ? 32'd2 : 32'(frame_width_q);
		if (w_lim > 32'(MAX_WIDTH)) w_lim = 32'(MAX_WIDTH);
		h_lim = (frame_height_q < GEOM_W'(2)) ? 32'd2 : 32'(frame_height_q);
		if (h_lim > 32'(MAX_HEIGHT)) h_lim = 32'(MAX_HEIGHT);
		row_end   = 32'(col_q) >= w_lim - 32'd1;
		frame_end = row_end && (32'(row_q) >= h_lim - 32'd1);

		grad_en   = (col_q != '0) && (row_q != '0);
		take_best = !best_seen_q || (peak_q > best_delta_q);
		bcol_n    = take_best ? col_q : best_col_q;
		brow_n    = take_best ? row_q : best_row_q;
		changed_n = changed_q + COUNT_W'(peak_q != '0);
		struct_n  = struct_q + COUNT_W'(mask_q[struct_bit_q]);
		censor_n  = censor_q + COUNT_W'(mask_q[censor_bit_q] | mask_q[bound_bit_q]);

		gb        = root_val;
		g_gap     = (gb > ga_q) ? ROOT_W'(gb - ga_q) : ROOT_W'(ga_q - gb);
		sum_ref_n  = grad_en ? SUM_W'(sum_ref_q + SUM_W'(ga_q)) : sum_ref_q;
		sum_cand_n = grad_en ? SUM_W'(sum_cand_q + SUM_W'(gb)) : sum_cand_q;
		gap_n      = grad_en ? SUM_W'(gap_q + SUM_W'(g_gap)) : gap_q;

		worst_x  = origin_x_q + COORD_W'(bcol_n);
		worst_y  = origin_y_q + COORD_W'(brow_n);
		luma_abs = (la_q > lb_q) ? SB'(la_q - lb_q) : SB'(lb_q - la_q);
		chroma_sat = (root_val > ROOT_W'({SB{1'b1}})) ? {SB{1'b1}} : root_val[SB-1:0];
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign fin_go   = (state_q == ST_FIN) && out_free;

	// sequencer
	always_comb begin
		state_d    = state_q;
		root_start = 1'b0;
		case (state_q)
			ST_IDLE:    if (s_tvalid) state_d = ST_LUMA_A;
			ST_LUMA_A:  if (last3) state_d = ST_LUMA_B;
			ST_LUMA_B:  if (last3) state_d = ST_SUM_D;
			ST_SUM_D:   if (last3) state_d = ST_CHROMA;
			ST_CHROMA:  if (last3) state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == 4'(DIV_STEPS - 1)) begin
					state_d    = ST_ROOT_CH;
					root_start = 1'b1;
				end
			end
			ST_ROOT_CH: if (!root_busy) state_d = grad_en ? ST_GRAD_R : ST_FIN;
			ST_GRAD_R: begin
				if (step_q[0]) begin
					state_d    = ST_ROOT_GR;
					root_start = 1'b1;
				end
			end
			ST_ROOT_GR: if (!root_busy) state_d = ST_GRAD_C;
			ST_GRAD_C: begin
				if (step_q[0]) begin
					state_d    = ST_ROOT_GC;
					root_start = 1'b1;
				end
			end
			ST_ROOT_GC: if (!root_busy) state_d = ST_FIN;
			ST_FIN:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_d != state_q) ? 4'd0 : step_q + 4'd1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= GEOM_W'(1024);
			frame_height_q <= GEOM_W'(1024);
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			struct_bit_q   <= BITSEL_W'(0);
			censor_bit_q   <= BITSEL_W'(1);
			bound_bit_q    <= BITSEL_W'(2);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[GEOM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[GEOM_W-1:0];
				REG_ORIGIN_X:     origin_x_q     <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Y:     origin_y_q     <= cfg_data[COORD_W-1:0];
				REG_STRUCT_BIT:   struct_bit_q   <= cfg_data[BITSEL_W-1:0];
				REG_CENSOR_BIT:   censor_bit_q   <= cfg_data[BITSEL_W-1:0];
				REG_BOUND_BIT:    bound_bit_q    <= cfg_data[BITSEL_W-1:0];
				default: ;
			endcase
		end
	end

	// frame accumulators and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			best_col_q   <= '0;
			best_row_q   <= '0;
			best_delta_q <= '0;
			best_seen_q  <= 1'b0;
			changed_q    <= '0;
			struct_q     <= '0;
			censor_q     <= '0;
			sum_ref_q    <= '0;
			sum_cand_q   <= '0;
			gap_q        <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (fin_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (fin_go) begin
				if (frame_end) begin
					col_q        <= '0;
					row_q        <= '0;
					best_col_q   <= '0;
					best_row_q   <= '0;
					best_delta_q <= '0;
					best_seen_q  <= 1'b0;
					changed_q    <= '0;
					struct_q     <= '0;
					censor_q     <= '0;
					sum_ref_q    <= '0;
					sum_cand_q   <= '0;
					gap_q        <= '0;
				end else begin
					best_col_q   <= bcol_n;
					best_row_q   <= brow_n;
					best_delta_q <= take_best ? peak_q : best_delta_q;
					best_seen_q  <= 1'b1;
					changed_q    <= changed_n;
					struct_q     <= struct_n;
					censor_q     <= censor_n;
					sum_ref_q    <= sum_ref_n;
					sum_cand_q   <= sum_cand_n;
					gap_q        <= gap_n;
					if (row_end) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (fin_go) begin
			line_mem[col_q] <= {lb_q, la_q};
		end
		up_q <= line_mem[col_q];
	end

	// datapath
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			for (int i = 0; i < 3; i++) begin
				a_q[i] <= s_tdata[i*SB +: SB];
				b_q[i] <= s_tdata[(i+3)*SB +: SB];
			end
			mask_q <= s_tuser;
			peak_q <= in_peak;
		end

		if (state_d != state_q) begin
			acc_q <= (state_d == ST_LUMA_A || state_d == ST_LUMA_B ||
			          state_d == ST_SUM_D) ? LUMA_ROUND : '0;
		end else if (state_q == ST_LUMA_A || state_q == ST_LUMA_B || state_q == ST_SUM_D ||
		             state_q == ST_CHROMA || state_q == ST_GRAD_R || state_q == ST_GRAD_C) begin
			acc_q <= acc_nxt;
		end

		if (state_q == ST_LUMA_A && last3) la_q <= acc_nxt[WEIGHT_FRAC +: SB];
		if (state_q == ST_LUMA_B && last3) lb_q <= acc_nxt[WEIGHT_FRAC +: SB];
		if (state_q == ST_SUM_D && last3) sl_q <= (SB+2)'(acc_nxt >>> WEIGHT_FRAC);

		if (state_q == ST_CHROMA && last3) begin
			rad_q  <= acc_nxt[RAD_W-1:0];
			rem3_q <= '0;
		end else if (state_q == ST_DIV) begin
			rad_q  <= {rad_q[RAD_W-DIV_DIGIT-1:0], div_q};
			rem3_q <= div_rem;
		end

		if (state_q == ST_ROOT_CH && !root_busy) chroma_q <= chroma_sat;
		if (state_q == ST_ROOT_GR && !root_busy) ga_q <= root_val;

		if (fin_go) begin
			left_ref_q  <= la_q;
			left_cand_q <= lb_q;
			diag_ref_q  <= up_q[SB-1:0];
			diag_cand_q <= up_q[2*SB-1:SB];
			m_tlast_q   <= frame_end;
			m_tdata_q   <= OUT_DATA_W'({
				frame_end ? gap_n      : {SUM_W{1'b0}},
				frame_end ? sum_cand_n : {SUM_W{1'b0}},
				frame_end ? sum_ref_n  : {SUM_W{1'b0}},
				frame_end ? worst_y    : {COORD_W{1'b0}},
				frame_end ? worst_x    : {COORD_W{1'b0}},
				frame_end ? censor_n   : {COUNT_W{1'b0}},
				frame_end ? struct_n   : {COUNT_W{1'b0}},
				frame_end ? changed_n  : {COUNT_W{1'b0}},
				chroma_q,
				luma_abs,
				peak_q
			});
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking bench for image_pair_difference_stats: per-pixel deltas and frame totals
// depends on ipds_pkg and the image_pair_difference_stats rtl
module tb_top
	import ipds_pkg::*;
();

	localparam int NUM_FIELDS  = 11;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int LINE_DEPTH  = 1024;
	localparam int RANDOM_ITEMS = 700;
	localparam int FIELD_OFF[NUM_FIELDS] = '{0, 16, 32, 48, 69, 90, 111, 143, 175, 212, 249};
	localparam int FIELD_WID[NUM_FIELDS] = '{16, 16, 16, 21, 21, 21, 32, 32, 37, 37, 37};
	localparam string FIELD_NAME[NUM_FIELDS] = '{"peak_channel_delta", "luma_delta",
		"chroma_delta", "changed_total", "structure_total", "censor_total", "worst_x",
		"worst_y", "edge_sum_ref", "edge_sum_cand", "edge_gap_sum"};

	typedef struct {
		logic [15:0] a_r, a_g, a_b;
		logic [15:0] b_r, b_g, b_b;
		logic [31:0] mask;
	} pixel_t;

	typedef struct packed {
		logic                         last;
		logic [NUM_FIELDS-1:0][36:0]  f;
	} pixel_stats_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic [MASK_W-1:0]      s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	image_pair_difference_stats dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [10:0] geom_w = 11'd1024, geom_h = 11'd1024;
	logic [31:0] org_x = '0, org_y = '0;
	logic [4:0]  bit_struct = 5'd0, bit_censor = 5'd1, bit_bound = 5'd2;
	int          pos_col = 0, pos_row = 0;
	logic [15:0] line_luma_a[LINE_DEPTH];
	logic [15:0] line_luma_b[LINE_DEPTH];
	logic [20:0] n_changed = '0, n_struct = '0, n_censor = '0;
	logic [15:0] top_delta = '0;
	logic        top_seen = 1'b0;
	logic [9:0]  top_col = '0, top_row = '0;
	logic [36:0] grad_a_sum = '0, grad_b_sum = '0, grad_gap = '0;
	longint      left_a = 0, left_b = 0, diag_a = 0, diag_b = 0;

	pixel_stats_t expected_results[$];
	int  mismatches = 0;
	int  cycles = 0;
	bit  calm = 1'b0;
	int  hold_left = 0;
	int  sent = 0;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint luma_q16(logic [15:0] r, logic [15:0] g, logic [15:0] b);
		return (longint'(W_RED) * r + longint'(W_GREEN) * g + longint'(W_BLUE) * b + 32768) >>> 16;
	endfunction

	function automatic void clear_frame_state();
		pos_col = 0; pos_row = 0;
		n_changed = '0; n_struct = '0; n_censor = '0;
		top_delta = '0; top_seen = 1'b0; top_col = '0; top_row = '0;
		grad_a_sum = '0; grad_b_sum = '0; grad_gap = '0;
		left_a = 0; left_b = 0; diag_a = 0; diag_b = 0;
	endfunction

	function automatic int eff_width();
		return geom_w < 2 ? 2 : (geom_w > LINE_DEPTH ? LINE_DEPTH : int'(geom_w));
	endfunction

	function automatic int eff_height();
		return geom_h < 2 ? 2 : (geom_h > 1024 ? 1024 : int'(geom_h));
	endfunction

	function automatic pixel_stats_t predict_pixel_stats(pixel_t p);
		pixel_stats_t e;
		longint d[3];
		longint m, peak, la, lb, s, sl, c, up_a, up_b, ga, gb;
		longint unsigned sq, chroma;
		int w, h, xi;
		bit row_end;
		e = '0;
		w = eff_width();
		h = eff_height();
		d[0] = longint'(p.b_r) - longint'(p.a_r);
		d[1] = longint'(p.b_g) - longint'(p.a_g);
		d[2] = longint'(p.b_b) - longint'(p.a_b);
		peak = 0;
		for (int k = 0; k < 3; k++) begin
			m = d[k] < 0 ? -d[k] : d[k];
			if (m > peak) peak = m;
		end
		la = luma_q16(p.a_r, p.a_g, p.a_b);
		lb = luma_q16(p.b_r, p.b_g, p.b_b);
		s = longint'(W_RED) * d[0] + longint'(W_GREEN) * d[1] + longint'(W_BLUE) * d[2];
		sl = (s + 32768) >>> 16;
		sq = 0;
		for (int k = 0; k < 3; k++) begin
			c = d[k] - sl;
			sq += longint'(c * c);
		end
		chroma = int_sqrt(sq / 3);
		if (chroma > 65535) chroma = 65535;

		if (peak != 0) n_changed++;
		if (!top_seen || peak > top_delta) begin
			top_seen = 1'b1; top_delta = 16'(peak);
			top_col = 10'(pos_col); top_row = 10'(pos_row);
		end
		if (p.mask[bit_struct]) n_struct++;
		if (p.mask[bit_censor] || p.mask[bit_bound]) n_censor++;

		xi = pos_col < LINE_DEPTH ? pos_col : LINE_DEPTH - 1;
		up_a = longint'(line_luma_a[xi]);
		up_b = longint'(line_luma_b[xi]);
		if (pos_col >= 1 && pos_row >= 1) begin
			ga = longint'(int_sqrt((up_a - diag_a) * (up_a - diag_a) +
				(left_a - diag_a) * (left_a - diag_a)));
			gb = longint'(int_sqrt((up_b - diag_b) * (up_b - diag_b) +
				(left_b - diag_b) * (left_b - diag_b)));
			grad_a_sum += 37'(ga);
			grad_b_sum += 37'(gb);
			grad_gap += 37'(gb > ga ? gb - ga : ga - gb);
		end
		diag_a = up_a; diag_b = up_b;
		line_luma_a[xi] = 16'(la);
		line_luma_b[xi] = 16'(lb);
		left_a = la; left_b = lb;

		row_end = pos_col >= w - 1;
		e.f[0] = 37'(peak);
		e.f[1] = 37'(lb > la ? lb - la : la - lb);
		e.f[2] = 37'(chroma);
		e.last = row_end && pos_row >= h - 1;
		if (e.last) begin
			e.f[3] = 37'(n_changed);
			e.f[4] = 37'(n_struct);
			e.f[5] = 37'(n_censor);
			e.f[6] = 37'(32'(org_x + top_col));
			e.f[7] = 37'(32'(org_y + top_row));
			e.f[8] = grad_a_sum;
			e.f[9] = grad_b_sum;
			e.f[10] = grad_gap;
			clear_frame_state();
		end else if (row_end) begin
			pos_col = 0; pos_row++;
		end else begin
			pos_col++;
		end
		return e;
	endfunction

	// receiver: random idling, long hold-offs on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 28);
		end
	end

	task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %0d at cycle %0d: %s expected %0d got %0d",
				mismatches, cycles, what, want, got);
	endtask

	// result checker
	always @(posedge clk) begin
		pixel_stats_t e;
		longint unsigned got;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected transaction", 0, 1);
			end else begin
				e = expected_results.pop_front();
				if (m_tlast !== e.last) note_mismatch("frame_last", e.last, m_tlast);
				for (int k = 0; k < NUM_FIELDS; k++) begin
					got = longint'(m_tdata >> FIELD_OFF[k]) & ((64'd1 << FIELD_WID[k]) - 1);
					if (got !== longint'(e.f[k])) note_mismatch(FIELD_NAME[k], e.f[k], got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_pixel(pixel_t p);
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 28) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {p.b_b, p.b_g, p.b_r, p.a_b, p.a_g, p.a_r};
		s_tuser <= p.mask;
		do @(posedge clk); while (!s_tready);
		expected_results.insert(expected_results.size(), predict_pixel_stats(p));
		sent++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		stop_sending();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FRAME_WIDTH:  geom_w = val[10:0];
			REG_FRAME_HEIGHT: geom_h = val[10:0];
			REG_ORIGIN_X:     org_x = val;
			REG_ORIGIN_Y:     org_y = val;
			REG_STRUCT_BIT:   bit_struct = val[4:0];
			REG_CENSOR_BIT:   bit_censor = val[4:0];
			REG_BOUND_BIT:    bit_bound = val[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup_frame(int w, int h, logic [31:0] ox, logic [31:0] oy,
		int sb, int cb, int bb);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_STRUCT_BIT, sb);
		write_reg(REG_CENSOR_BIT, cb);
		write_reg(REG_BOUND_BIT, bb);
	endtask

	function automatic logic [15:0] near(logic [15:0] v);
		int t;
		t = int'(v) + $signed($urandom_range(0, 8)) - 4;
		return t < 0 ? 16'd0 : (t > 65535 ? 16'hFFFF : 16'(t));
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		int mode;
		mode = $urandom_range(0, 9);
		p.a_r = 16'($urandom); p.a_g = 16'($urandom); p.a_b = 16'($urandom);
		p.b_r = 16'($urandom); p.b_g = 16'($urandom); p.b_b = 16'($urandom);
		p.mask = $urandom_range(0, 4) == 0 ? 32'd0 : $urandom;
		case (mode)
			0: begin
				p.b_r = p.a_r; p.b_g = p.a_g; p.b_b = p.a_b;
			end
			1: begin
				p.a_r = {16{p.a_r[0]}}; p.a_g = {16{p.a_g[0]}}; p.a_b = {16{p.a_b[0]}};
				p.b_r = {16{p.b_r[0]}}; p.b_g = {16{p.b_g[0]}}; p.b_b = {16{p.b_b[0]}};
			end
			2, 3: begin
				p.b_r = near(p.a_r); p.b_g = near(p.a_g); p.b_b = near(p.a_b);
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic send_random(int n);
		for (int i = 0; i < n; i++) send_pixel(random_pixel());
	endtask

	task automatic test_directed_pixels();
		pixel_t p;
		setup_frame(5, 4, 32'd0, 32'd0, 0, 1, 2);
		for (int i = 0; i < 20; i++) begin
			p = '{default: '0};
			case (i)
				1: p = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0, 32'h1};
				2: p = '{16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h2};
				3: p = '{16'h0, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h0, 32'h4};
				4: p = '{16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'h0, 32'h6};
				5: p = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 32'hFFFFFFFF};
				6: p = '{16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 32'h8};
				7: p = '{16'h1234, 16'h5678, 16'h9ABC, 16'h1234, 16'h5678, 16'h9ABC, 32'h7};
				8: p = '{16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 32'h80000000};
				9: p = '{16'h8000, 16'h8000, 16'h8000, 16'h8001, 16'h7FFF, 16'h8000, 32'h0};
				// equal peak as an earlier pixel: first one must stay the worst
				10: p = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0, 32'h3};
				default: p = random_pixel();
			endcase
			send_pixel(p);
		end
		wait_drained();
	endtask

	task automatic test_geometry_extremes();
		setup_frame(1, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 31, 31, 0);
		send_random(4);
		wait_drained();
		// oversized width: first row must end at the widest column
		setup_frame(2047, 2047, 32'hFFFFFE00, 32'd7, 5, 0, 31);
		send_random(1025);
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 2);
		write_reg(REG_FRAME_HEIGHT, 2);
		send_random(1);
		wait_drained();
	endtask

	task automatic test_midframe_geometry();
		// shrink at a row boundary: the shortened row ends the frame
		setup_frame(6, 6, 32'd100, 32'd200, 1, 2, 3);
		send_random(12);
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 3);
		send_random(3);
		wait_drained();
	endtask

	task automatic test_backpressure();
		setup_frame(5, 3, $urandom, $urandom, 4, 9, 17);
		hold_left = 400;
		send_random(30);
		wait_drained();
	endtask

	task automatic test_random_frames();
		int w, h, start;
		start = sent;
		while (sent - start < RANDOM_ITEMS) begin
			w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 40) : $urandom_range(2, 12);
			h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 20) : $urandom_range(2, 8);
			setup_frame(w, h, $urandom, $urandom, $urandom_range(0, 31),
				$urandom_range(0, 31), $urandom_range(0, 31));
			calm = (sent - start > 300 && sent - start < 500);
			send_random(eff_width() * eff_height());
			if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(20, 200);
			wait_drained();
		end
		calm = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < LINE_DEPTH; i++) begin
			line_luma_a[i] = '0;
			line_luma_b[i] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_pixels();
		test_geometry_extremes();
		test_midframe_geometry();
		test_backpressure();
		test_random_frames();
		wait_drained();
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
